// ===== hdl/dbc_pkg.sv =====
package dbc_pkg;

  // Configuration port widths and register indexes
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TIME = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIN_INVERT    = 8'd1;

  localparam logic [15:0] DEBOUNCE_RESET = 16'd35;
  localparam logic [15:0] CNT_MAX        = 16'hFFFF;

  // Request modes
  typedef enum logic [2:0] {
    MODE_SAMPLE       = 3'd0,
    MODE_TAKE_PRESS   = 3'd1,
    MODE_TAKE_RELEASE = 3'd2,
    MODE_READ_PRESS   = 3'd3,
    MODE_READ_RELEASE = 3'd4
  } mode_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic        raw_level;
    logic [31:0] now_time;
    logic        clear_total;
  } req_t;

  typedef struct packed {
    logic        changed;
    logic        is_pressed;
    logic        event_taken;
    logic [15:0] total_value;
    logic [31:0] last_change;
  } rsp_t;

  typedef struct packed {
    logic [15:0] debounce_time;
    logic        pin_inverted;
  } cfg_t;

endpackage

// ===== hdl/dbc_stream_if.sv =====
interface dbc_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface dbc_cfg_if ();
  logic                           valid;
  logic                           ready;
  logic [dbc_pkg::CFG_IDX_W-1:0]  index;
  logic [dbc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/dbc_core.sv =====
module dbc_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          advance_i,
  input  dbc_pkg::cfg_t cfg_i,
  input  dbc_pkg::req_t req_i,
  output dbc_pkg::rsp_t rsp_o
);
  import dbc_pkg::*;

  logic        cand_level_q, cand_level_d;
  logic [31:0] cand_time_q, cand_time_d;
  logic        stable_q, stable_d;
  logic [31:0] change_time_q, change_time_d;
  logic [15:0] press_total_q, press_total_d;
  logic [15:0] release_total_q, release_total_d;
  logic [15:0] press_pend_q, press_pend_d;
  logic [15:0] release_pend_q, release_pend_d;

  logic        pressed;
  logic [31:0] held;
  logic        settle_ok;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == CNT_MAX) ? v : v + 16'd1;
  endfunction

  // Map the pin to pressed and measure how long the candidate has held
  assign pressed   = req_i.raw_level ^ cfg_i.pin_inverted;
  assign held      = req_i.now_time - cand_time_q;
  assign settle_ok = !held[31] && (held >= {16'd0, cfg_i.debounce_time});

  // Work out the next state and the response for one request
  always_comb begin
    cand_level_d    = cand_level_q;
    cand_time_d     = cand_time_q;
    stable_d        = stable_q;
    change_time_d   = change_time_q;
    press_total_d   = press_total_q;
    release_total_d = release_total_q;
    press_pend_d    = press_pend_q;
    release_pend_d  = release_pend_q;
    rsp_o           = '0;

    unique case (mode_e'(req_i.mode))
      MODE_SAMPLE: begin
        if (pressed != cand_level_q) begin
          cand_level_d = pressed;
          cand_time_d  = req_i.now_time;
        end else if (pressed != stable_q && settle_ok) begin
          stable_d      = pressed;
          change_time_d = req_i.now_time;
          rsp_o.changed = 1'b1;
          if (pressed) begin
            press_total_d = sat_inc(press_total_q);
            press_pend_d  = sat_inc(press_pend_q);
          end else begin
            release_total_d = sat_inc(release_total_q);
            release_pend_d  = sat_inc(release_pend_q);
          end
        end
      end
      MODE_TAKE_PRESS: begin
        if (press_pend_q != '0) begin
          press_pend_d      = press_pend_q - 16'd1;
          rsp_o.event_taken = 1'b1;
        end
      end
      MODE_TAKE_RELEASE: begin
        if (release_pend_q != '0) begin
          release_pend_d    = release_pend_q - 16'd1;
          rsp_o.event_taken = 1'b1;
        end
      end
      MODE_READ_PRESS: begin
        rsp_o.total_value = press_total_q;
        if (req_i.clear_total) press_total_d = '0;
      end
      MODE_READ_RELEASE: begin
        rsp_o.total_value = release_total_q;
        if (req_i.clear_total) release_total_d = '0;
      end
      default: ;
    endcase

    rsp_o.is_pressed  = stable_d;
    rsp_o.last_change = change_time_d;
  end

  // Commit state when the request moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_level_q    <= 1'b0;
      cand_time_q     <= '0;
      stable_q        <= 1'b0;
      change_time_q   <= '0;
      press_total_q   <= '0;
      release_total_q <= '0;
      press_pend_q    <= '0;
      release_pend_q  <= '0;
    end else if (advance_i) begin
      cand_level_q    <= cand_level_d;
      cand_time_q     <= cand_time_d;
      stable_q        <= stable_d;
      change_time_q   <= change_time_d;
      press_total_q   <= press_total_d;
      release_total_q <= release_total_d;
      press_pend_q    <= press_pend_d;
      release_pend_q  <= release_pend_d;
    end
  end

endmodule

// ===== hdl/button_debouncer_with_event_counts_top.sv =====
// Time-based debouncer for one push button, with press/release totals and
// pending-event counts.
//
// in_i carries requests (mode, raw_level, now_time, clear_total); out_o
// carries one response per request (changed, is_pressed, event_taken,
// total_value, last_change). Both use valid/ready; a transfer happens when
// both are high. cfg_i writes debounce_time (index 0) and the pin inversion
// flag (index 1); other indexes are ignored. cfg_i is always ready.
//
// A request is captured in an input register, processed by the core and
// lands in the output register, which presents the response on out_o.
// One request per cycle is sustained while out_o is drained.
// If out_o stalls, the response holds, one more request waits in the input
// register and in_i then drops ready until the response is taken.
//
// Reset clears the debounce state, counters and valid flags and loads
// debounce_time = 35 with pin inversion off; the button reads as released.
module button_debouncer_with_event_counts_top (
  input  logic clk_i,
  input  logic rst_ni,
  dbc_stream_if.sink   in_i,
  dbc_stream_if.source out_o,
  dbc_cfg_if.sink      cfg_i
);
  import dbc_pkg::*;

  req_t in_q;
  logic in_valid_q;
  rsp_t out_q;
  logic out_valid_q;
  cfg_t cfg_q;
  rsp_t rsp;
  logic advance;

  // Move the held request forward when the result register is free or being taken
  assign advance     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;
  assign out_o.valid = out_valid_q;
  assign out_o.payload = out_q;
  assign cfg_i.ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_time <= DEBOUNCE_RESET;
      cfg_q.pin_inverted  <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_DEBOUNCE_TIME: cfg_q.debounce_time <= cfg_i.data;
        CFG_PIN_INVERT:    cfg_q.pin_inverted  <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // Hold the accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.payload;
    end
  end

  dbc_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .cfg_i     (cfg_q),
    .req_i     (in_q),
    .rsp_o     (rsp)
  );

  // Hold the response until the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= rsp;
    end
  end

  // A state change only comes from a sample request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && rsp.changed |-> in_q.mode == MODE_SAMPLE)
    else $error("state change reported outside sample mode");

  // A processed request always lands in the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed request lost");

  // An accepted change stamps the request's timestamp
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && rsp.changed |=> out_q.last_change == $past(in_q.now_time))
    else $error("last_change does not match the change timestamp");

  // A taken event comes with no state change and a zero total_value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && rsp.event_taken |-> !rsp.changed && rsp.total_value == '0)
    else $error("event taken together with another response field");

endmodule

// ===== verif/dbc_response_checker.sv =====
`timescale 1ns / 100ps

module dbc_response_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  dbc_stream_if       req_mon,
  dbc_stream_if       rsp_mon,
  dbc_cfg_if          cfg_mon,
  output int unsigned outstanding_o,
  output int unsigned errors_o
);
  import dbc_pkg::*;

  // Register copies
  logic [15:0] settle_len;
  logic        pin_inverted;

  // Debounce state and counters
  logic        cand_pressed;
  logic [31:0] cand_ms;
  logic        stable_pressed;
  logic [31:0] change_ms;
  logic [15:0] press_total;
  logic [15:0] release_total;
  logic [15:0] press_pending;
  logic [15:0] release_pending;

  rsp_t expected_q[$];

  function automatic logic [15:0] sat_incr(input logic [15:0] count);
    return (count == CNT_MAX) ? count : count + 16'd1;
  endfunction

  // Advance the button state by one request and build its response
  function automatic rsp_t apply_request(input req_t req);
    rsp_t        rsp;
    logic        pressed;
    logic [31:0] held;
    rsp = '0;
    case (req.mode)
      MODE_SAMPLE: begin
        pressed = pin_inverted ? ~req.raw_level : req.raw_level;
        held    = req.now_time - cand_ms;
        if (pressed != cand_pressed) begin
          // Restart the hold timer on a new level
          cand_pressed = pressed;
          cand_ms      = req.now_time;
        end else if (pressed != stable_pressed && !held[31] &&
                     held >= {16'd0, settle_len}) begin
          stable_pressed = pressed;
          change_ms      = req.now_time;
          rsp.changed    = 1'b1;
          if (pressed) begin
            press_total   = sat_incr(press_total);
            press_pending = sat_incr(press_pending);
          end else begin
            release_total   = sat_incr(release_total);
            release_pending = sat_incr(release_pending);
          end
        end
      end
      MODE_TAKE_PRESS: begin
        if (press_pending != 16'd0) begin
          press_pending   = press_pending - 16'd1;
          rsp.event_taken = 1'b1;
        end
      end
      MODE_TAKE_RELEASE: begin
        if (release_pending != 16'd0) begin
          release_pending = release_pending - 16'd1;
          rsp.event_taken = 1'b1;
        end
      end
      MODE_READ_PRESS: begin
        rsp.total_value = press_total;
        if (req.clear_total) press_total = '0;
      end
      MODE_READ_RELEASE: begin
        rsp.total_value = release_total;
        if (req.clear_total) release_total = '0;
      end
      default: ;
    endcase
    rsp.is_pressed  = stable_pressed;
    rsp.last_change = change_ms;
    return rsp;
  endfunction

  // Match a response against the oldest prediction
  task automatic compare_response(input rsp_t got);
    rsp_t want;
    if (expected_q.size() == 0) begin
      $error("response with no request outstanding: %p", got);
      errors_o++;
      return;
    end
    want = expected_q.pop_front();
    if (got.changed !== want.changed) begin
      $error("changed: expected %0d, got %0d", want.changed, got.changed);
      errors_o++;
    end
    if (got.is_pressed !== want.is_pressed) begin
      $error("is_pressed: expected %0d, got %0d", want.is_pressed, got.is_pressed);
      errors_o++;
    end
    if (got.event_taken !== want.event_taken) begin
      $error("event_taken: expected %0d, got %0d", want.event_taken, got.event_taken);
      errors_o++;
    end
    if (got.total_value !== want.total_value) begin
      $error("total_value: expected %0d, got %0d", want.total_value, got.total_value);
      errors_o++;
    end
    if (got.last_change !== want.last_change) begin
      $error("last_change: expected 0x%08h, got 0x%08h", want.last_change, got.last_change);
      errors_o++;
    end
  endtask

  // Watch all three channels at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_len      = DEBOUNCE_RESET;
      pin_inverted    = 1'b0;
      cand_pressed    = 1'b0;
      cand_ms         = '0;
      stable_pressed  = 1'b0;
      change_ms       = '0;
      press_total     = '0;
      release_total   = '0;
      press_pending   = '0;
      release_pending = '0;
      expected_q.delete();
      outstanding_o   = 0;
      errors_o        = 0;
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) compare_response(rsp_mon.payload);
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_DEBOUNCE_TIME: settle_len   = cfg_mon.data;
          CFG_PIN_INVERT:    pin_inverted = cfg_mon.data[0];
          default: ;
        endcase
      end
      if (req_mon.valid && req_mon.ready) expected_q.push_back(apply_request(req_mon.payload));
      outstanding_o = expected_q.size();
    end
  end

endmodule

// ===== verif/button_debouncer_with_event_counts_top_test.sv =====
`timescale 1ns / 100ps

module button_debouncer_with_event_counts_top_test;
  import dbc_pkg::*;

  localparam int unsigned     RANDOM_ITEMS  = 1600;
  localparam int unsigned     PHASES        = 6;
  localparam int unsigned     BURST_PRESSES = 16;
  localparam longint unsigned CYCLE_LIMIT   = 4_000_000;
  localparam logic [2:0]      MODE_SPARE_LO = 3'd5;
  localparam logic [2:0]      MODE_SPARE_HI = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 8'hFF;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  dbc_stream_if #(.payload_t(req_t)) req_if ();
  dbc_stream_if #(.payload_t(rsp_t)) rsp_if ();
  dbc_cfg_if                         cfg_if ();

  int unsigned     outstanding;
  int unsigned     mismatches;
  bit              full_speed = 1'b0;
  longint unsigned cycle_count = 0;

  // Pin waveform state for sample requests
  logic [31:0] now_ms      = '0;
  logic [31:0] level_ms    = '0;
  logic        steady_lvl  = 1'b0;
  logic        sent_lvl    = 1'b0;
  logic [15:0] cur_debounce = DEBOUNCE_RESET;

  // Stall driver state
  int unsigned sink_run   = 0;
  bit          sink_state = 1'b0;

  button_debouncer_with_event_counts_top dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if),
    .out_o (rsp_if),
    .cfg_i (cfg_if)
  );

  dbc_response_checker response_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_mon      (req_if),
    .rsp_mon      (rsp_if),
    .cfg_mon      (cfg_if),
    .outstanding_o(outstanding),
    .errors_o     (mismatches)
  );

  always #5 clk_i = ~clk_i;

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Mostly short pauses, a few long ones
  function automatic int unsigned pause_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Toggle response ready in runs of random length
  always @(negedge clk_i) begin
    if (full_speed) begin
      rsp_if.ready <= 1'b1;
    end else if (sink_run != 0) begin
      sink_run = sink_run - 1;
    end else begin
      sink_state = ~sink_state;
      rsp_if.ready <= sink_state;
      sink_run = sink_state ? $urandom_range(1, 30) : pause_len() - 1;
    end
  end

  function automatic req_t make_req(input logic [2:0] mode, input logic level,
                                    input logic [31:0] ms, input logic clear);
    req_t req;
    req.mode        = mode;
    req.raw_level   = level;
    req.now_time    = ms;
    req.clear_total = clear;
    return req;
  endfunction

  // Build a random request; samples follow a bouncing pin on a moving clock
  function automatic req_t random_request();
    req_t        req;
    int unsigned r;
    req = make_req(MODE_SAMPLE, 1'($urandom_range(0, 1)), $urandom,
                   1'($urandom_range(0, 1)));
    r = $urandom_range(0, 99);
    if (r < 60) begin
      if ($urandom_range(0, 99) < 8) steady_lvl = ~steady_lvl;
      req.raw_level = ($urandom_range(0, 99) < 15) ? ~steady_lvl : steady_lvl;
      r = $urandom_range(0, 99);
      if (r < 4) begin
        // jump anywhere, backwards included
        now_ms = $urandom;
      end else if (r < 20) begin
        // land right around the debounce boundary
        now_ms = level_ms + cur_debounce + $urandom_range(0, 2) - 1;
      end else begin
        now_ms = now_ms + $urandom_range(0, cur_debounce / 3 + 2);
      end
      if (req.raw_level != sent_lvl) begin
        sent_lvl = req.raw_level;
        level_ms = now_ms;
      end
      req.now_time = now_ms;
    end else if (r < 70) begin
      req.mode = MODE_TAKE_PRESS;
    end else if (r < 80) begin
      req.mode = MODE_TAKE_RELEASE;
    end else if (r < 88) begin
      req.mode = MODE_READ_PRESS;
    end else if (r < 96) begin
      req.mode = MODE_READ_RELEASE;
    end else begin
      req.mode = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
    end
    return req;
  endfunction

  // Offer one request after a random gap and hold it until accepted
  task automatic send_request(input req_t req);
    int unsigned gap;
    gap = (full_speed || $urandom_range(0, 1) == 0) ? 0 : pause_len();
    if (gap != 0) begin
      @(negedge clk_i);
      req_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    req_if.valid   <= 1'b1;
    req_if.payload <= req;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // Drop valid and wait for every response
  task automatic drain_responses();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Reprogram both registers while idle, plus one write to an unused index
  task automatic configure(input logic [15:0] debounce, input logic low);
    drain_responses();
    write_register(CFG_DEBOUNCE_TIME, debounce);
    write_register(CFG_PIN_INVERT, {15'($urandom_range(0, 16'h7FFF)), low});
    write_register(CFG_IDX_W'($urandom_range(CFG_IDX_SPARE_LO, CFG_IDX_SPARE_HI)),
                   CFG_DATA_W'($urandom));
    cur_debounce = debounce;
    level_ms     = now_ms;
  endtask

  initial begin
    logic [15:0] phase_debounce [PHASES];
    logic        phase_low      [PHASES];
    int unsigned per_phase;
    logic [31:0] burst_ms;

    req_if.valid   = 1'b0;
    req_if.payload = '0;
    rsp_if.ready   = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = '0;
    cfg_if.data    = '0;

    // Hold reset low, then release it
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Empty counters, spare modes, then timing edge cases at reset settings
    send_request(make_req(MODE_READ_PRESS, 1'b1, 32'hFFFF_FFFF, 1'b0));
    send_request(make_req(MODE_TAKE_PRESS, 1'b1, 32'hFFFF_FFFF, 1'b1));
    send_request(make_req(MODE_TAKE_RELEASE, 1'b0, 32'h0, 1'b1));
    send_request(make_req(MODE_SPARE_LO, 1'b1, 32'hFFFF_FFFF, 1'b1));
    send_request(make_req(MODE_SPARE_LO + 3'd1, 1'b0, 32'h5A5A_A5A5, 1'b0));
    send_request(make_req(MODE_SPARE_HI, 1'b1, 32'h0, 1'b1));
    send_request(make_req(MODE_SAMPLE, 1'b1, 32'd100, 1'b0));
    send_request(make_req(MODE_SAMPLE, 1'b1, 32'd134, 1'b1));
    send_request(make_req(MODE_SAMPLE, 1'b1, 32'd135, 1'b0));
    // release held across the timestamp wrap
    send_request(make_req(MODE_SAMPLE, 1'b0, 32'hFFFF_FFF0, 1'b0));
    send_request(make_req(MODE_SAMPLE, 1'b0, 32'h0000_0013, 1'b0));
    // time running backwards, then the signed limit from both sides
    send_request(make_req(MODE_SAMPLE, 1'b1, 32'h0000_0020, 1'b0));
    send_request(make_req(MODE_SAMPLE, 1'b1, 32'h0000_0010, 1'b0));
    send_request(make_req(MODE_SAMPLE, 1'b1, 32'h8000_0020, 1'b0));
    send_request(make_req(MODE_SAMPLE, 1'b1, 32'h8000_001F, 1'b0));
    send_request(make_req(MODE_READ_PRESS, 1'b0, 32'h0, 1'b1));
    send_request(make_req(MODE_READ_PRESS, 1'b1, 32'hFFFF_FFFF, 1'b0));
    send_request(make_req(MODE_READ_RELEASE, 1'b1, 32'h0, 1'b0));
    send_request(make_req(MODE_READ_RELEASE, 1'b0, 32'hFFFF_FFFF, 1'b1));
    repeat (3) send_request(make_req(MODE_TAKE_PRESS, 1'b0, 32'h0, 1'b0));
    repeat (2) send_request(make_req(MODE_TAKE_RELEASE, 1'b1, 32'hFFFF_FFFF, 1'b0));
    now_ms = 32'h8000_0100;

    // Random traffic under several register settings, extremes included
    phase_debounce[0] = 16'd0;                        phase_low[0] = 1'b1;
    phase_debounce[1] = 16'hFFFF;                     phase_low[1] = 1'b0;
    phase_debounce[2] = 16'd1;                        phase_low[2] = 1'b1;
    phase_debounce[3] = 16'($urandom_range(2, 300));  phase_low[3] = 1'b0;
    phase_debounce[4] = 16'($urandom_range(2, 300));  phase_low[4] = 1'b1;
    phase_debounce[5] = DEBOUNCE_RESET;               phase_low[5] = 1'b0;
    per_phase = RANDOM_ITEMS / PHASES;
    for (int p = 0; p < PHASES; p++) begin
      configure(phase_debounce[p], phase_low[p]);
      for (int unsigned i = 0; i < per_phase; i++) begin
        full_speed = (i % 100) >= 70;
        // hold off mid-phase until every response is back
        if (i == per_phase / 2) drain_responses();
        send_request(random_request());
      end
    end

    // Run press/release bursts back to back with no debounce delay
    configure(16'd0, 1'b0);
    full_speed = 1'b1;
    burst_ms = now_ms;
    for (int unsigned i = 0; i < BURST_PRESSES; i++) begin
      send_request(make_req(MODE_SAMPLE, 1'b1, burst_ms, 1'b0));
      send_request(make_req(MODE_SAMPLE, 1'b1, burst_ms + 32'd1, 1'b0));
      send_request(make_req(MODE_SAMPLE, 1'b0, burst_ms + 32'd2, 1'b0));
      send_request(make_req(MODE_SAMPLE, 1'b0, burst_ms + 32'd3, 1'b0));
      burst_ms = burst_ms + 32'd4;
    end
    full_speed = 1'b0;
    send_request(make_req(MODE_READ_PRESS, 1'b0, 32'h0, 1'b0));
    send_request(make_req(MODE_READ_RELEASE, 1'b0, 32'h0, 1'b0));
    repeat (2) send_request(make_req(MODE_TAKE_PRESS, 1'b0, 32'h0, 1'b0));
    send_request(make_req(MODE_TAKE_RELEASE, 1'b0, 32'h0, 1'b0));
    send_request(make_req(MODE_READ_PRESS, 1'b0, 32'h0, 1'b1));
    send_request(make_req(MODE_READ_RELEASE, 1'b0, 32'h0, 1'b1));
    send_request(make_req(MODE_READ_PRESS, 1'b0, 32'h0, 1'b0));

    drain_responses();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
